// ===== hw/rtl/gtp_pkg.sv =====
package gtp_pkg;

   // Field and register widths
   localparam int SAMPLE_W   = 16;
   localparam int COEFF_W    = 19;
   localparam int BLEN_W     = 13;
   localparam int POWER_W    = 32;
   localparam int MAX_BLOCK  = 4096;

   // Recurrence state and datapath widths
   localparam int STATE_W    = 40;
   localparam int FRAC_W     = 16;
   localparam int SUM_W      = STATE_W + 4;
   localparam int LIMB_W     = 20;
   localparam int PROD_W     = 2 * LIMB_W;
   localparam int M_W        = 2 * STATE_W;
   localparam int ACC_W      = 100;
   localparam int SHAMT_W    = 6;

   // Normalization: power = floor(Q / 2^15 / N^2)
   localparam int QSCALE_SH  = 15;
   localparam int QUO_W      = POWER_W;
   localparam int SAT_LO     = QSCALE_SH + QUO_W;
   localparam int DIV_W      = 25;
   localparam int REM_W      = DIV_W - 1;
   localparam int CNT_W      = $clog2(QUO_W);

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = COEFF_W;
   localparam logic [CSR_IDX_W-1:0] CSR_COEFF_B   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_LEN = 1'd1;
   localparam logic [COEFF_W-1:0]   COEFF_B_RST   = '0;
   localparam logic [BLEN_W-1:0]    BLOCK_LEN_RST = 13'd205;

   // Operand select codes for the shared multiplier
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_B    = 4'd0;
   localparam logic [OP_W-1:0] OP_S0LO = 4'd1;
   localparam logic [OP_W-1:0] OP_S0HI = 4'd2;
   localparam logic [OP_W-1:0] OP_S1LO = 4'd3;
   localparam logic [OP_W-1:0] OP_S1HI = 4'd4;
   localparam logic [OP_W-1:0] OP_M0   = 4'd5;
   localparam logic [OP_W-1:0] OP_M1   = 4'd6;
   localparam logic [OP_W-1:0] OP_M2   = 4'd7;
   localparam logic [OP_W-1:0] OP_M3   = 4'd8;
   localparam logic [OP_W-1:0] OP_N    = 4'd9;

   // Sign rule applied to a partial product
   localparam int NEGK_W = 2;
   localparam logic [NEGK_W-1:0] NEGK_NONE  = 2'd0;
   localparam logic [NEGK_W-1:0] NEGK_REC   = 2'd1;
   localparam logic [NEGK_W-1:0] NEGK_CROSS = 2'd2;

   // Micro-program step numbers
   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] STEP_REC_FIRST = 5'd0;
   localparam logic [STEP_W-1:0] STEP_REC_END   = 5'd1;
   localparam logic [STEP_W-1:0] STEP_PWR_FIRST = 5'd2;
   localparam logic [STEP_W-1:0] STEP_NN        = 5'd18;

   typedef struct packed {
      logic [OP_W-1:0]    opa;
      logic [OP_W-1:0]    opb;
      logic [SHAMT_W-1:0] shamt;
      logic               acc_en;
      logic               clr;
      logic               save_m;
      logic [NEGK_W-1:0]  negk;
   } uop_type;

   typedef struct packed {
      logic               en;
      logic               clr;
      logic               neg;
      logic [SHAMT_W-1:0] shamt;
   } mac_ctl_type;

   function automatic uop_type mk_uop(input logic [OP_W-1:0] opa,
                                      input logic [OP_W-1:0] opb,
                                      input logic [SHAMT_W-1:0] shamt,
                                      input logic acc_en,
                                      input logic clr,
                                      input logic save_m,
                                      input logic [NEGK_W-1:0] negk);
      uop_type u;
      u.opa    = opa;
      u.opb    = opb;
      u.shamt  = shamt;
      u.acc_en = acc_en;
      u.clr    = clr;
      u.save_m = save_m;
      u.negk   = negk;
      return u;
   endfunction

   // Recurrence: B*s1. Power: M = |s0||s1|, then s0^2 + s1^2 scaled by 2^16,
   // then -B*s0*s1, then N*N for the divisor.
   function automatic uop_type gtp_uop(input logic [STEP_W-1:0] step);
      uop_type u;
      case (step)
         5'd0:    u = mk_uop(OP_B,    OP_S1LO, 6'd0,  1'b1, 1'b1, 1'b0, NEGK_REC);
         5'd1:    u = mk_uop(OP_B,    OP_S1HI, 6'd20, 1'b1, 1'b0, 1'b0, NEGK_REC);
         5'd2:    u = mk_uop(OP_S0LO, OP_S1LO, 6'd0,  1'b1, 1'b1, 1'b0, NEGK_NONE);
         5'd3:    u = mk_uop(OP_S0LO, OP_S1HI, 6'd20, 1'b1, 1'b0, 1'b0, NEGK_NONE);
         5'd4:    u = mk_uop(OP_S0HI, OP_S1LO, 6'd20, 1'b1, 1'b0, 1'b0, NEGK_NONE);
         5'd5:    u = mk_uop(OP_S0HI, OP_S1HI, 6'd40, 1'b1, 1'b0, 1'b0, NEGK_NONE);
         5'd6:    u = mk_uop(OP_S0LO, OP_S0LO, 6'd16, 1'b1, 1'b1, 1'b1, NEGK_NONE);
         5'd7:    u = mk_uop(OP_S0LO, OP_S0HI, 6'd36, 1'b1, 1'b0, 1'b0, NEGK_NONE);
         5'd8:    u = mk_uop(OP_S0HI, OP_S0LO, 6'd36, 1'b1, 1'b0, 1'b0, NEGK_NONE);
         5'd9:    u = mk_uop(OP_S0HI, OP_S0HI, 6'd56, 1'b1, 1'b0, 1'b0, NEGK_NONE);
         5'd10:   u = mk_uop(OP_S1LO, OP_S1LO, 6'd16, 1'b1, 1'b0, 1'b0, NEGK_NONE);
         5'd11:   u = mk_uop(OP_S1LO, OP_S1HI, 6'd36, 1'b1, 1'b0, 1'b0, NEGK_NONE);
         5'd12:   u = mk_uop(OP_S1HI, OP_S1LO, 6'd36, 1'b1, 1'b0, 1'b0, NEGK_NONE);
         5'd13:   u = mk_uop(OP_S1HI, OP_S1HI, 6'd56, 1'b1, 1'b0, 1'b0, NEGK_NONE);
         5'd14:   u = mk_uop(OP_B,    OP_M0,   6'd0,  1'b1, 1'b0, 1'b0, NEGK_CROSS);
         5'd15:   u = mk_uop(OP_B,    OP_M1,   6'd20, 1'b1, 1'b0, 1'b0, NEGK_CROSS);
         5'd16:   u = mk_uop(OP_B,    OP_M2,   6'd40, 1'b1, 1'b0, 1'b0, NEGK_CROSS);
         5'd17:   u = mk_uop(OP_B,    OP_M3,   6'd60, 1'b1, 1'b0, 1'b0, NEGK_CROSS);
         5'd18:   u = mk_uop(OP_N,    OP_N,    6'd0,  1'b0, 1'b0, 1'b0, NEGK_NONE);
         default: u = mk_uop(OP_N,    OP_N,    6'd0,  1'b0, 1'b0, 1'b0, NEGK_NONE);
      endcase
      return u;
   endfunction

endpackage

// ===== hw/rtl/gtp_if.sv =====
interface gtp_req_if;
   logic                          valid;
   logic                          ready;
   logic [gtp_pkg::SAMPLE_W-1:0]  sample;
   logic                          last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface

interface gtp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [gtp_pkg::POWER_W-1:0]   power;

   modport source (output valid, output power, input ready);
   modport sink   (input valid, input power, output ready);
endinterface

// ===== hw/rtl/goertzel_tone_power.sv =====
// Single-bin Goertzel tone power detector. Each accepted sample runs one step of
// s0 = x + B*s1 - s2 (B in Q3.16 from coeff_b) on a shared 20x20 multiply-
// accumulate unit, so a sample not marked last occupies the block for the
// transfer cycle, two partial products and a saturating update before the
// next sample can be taken. A sample marked last holds off the next sample
// longer: 17 more multiply-accumulate steps form 2*(s0^2 + s1^2 - B*s0*s1) and
// N^2, a range check follows, a bit-serial divider forms the normalized power
// and hands it over, and the result is loaded into the output register once
// the previous result has been taken. When the power is zero or saturates the
// divider is skipped. The state is cleared after each block. Power saturates
// at all ones and is zero when the quadratic form is negative. block_len of
// zero acts as 1, above 4096 as 4096.
module goertzel_tone_power (
   input  logic                              clock,
   input  logic                              reset,
   gtp_req_if.sink                           req_chan,
   gtp_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [gtp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gtp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] S_IDLE = 3'd0;
   localparam logic [ST_W-1:0] S_MUL  = 3'd1;
   localparam logic [ST_W-1:0] S_FIN  = 3'd2;
   localparam logic [ST_W-1:0] S_DSET = 3'd3;
   localparam logic [ST_W-1:0] S_DIV  = 3'd4;
   localparam logic [ST_W-1:0] S_OUT  = 3'd5;

   logic [ST_W-1:0]                   state_ff, state_in;
   logic [gtp_pkg::STEP_W-1:0]        step_ff, step_in;
   logic [gtp_pkg::COEFF_W-1:0]       coeff_b_ff;
   logic [gtp_pkg::BLEN_W-1:0]        block_len_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [gtp_pkg::POWER_W-1:0]       power_ff;
   logic [gtp_pkg::SAMPLE_W-1:0]      x_ff;
   logic                              last_ff;
   logic [gtp_pkg::STATE_W-1:0]       s0_ff, s1_ff, s2_ff;
   logic [gtp_pkg::M_W-1:0]           m_ff;
   logic [gtp_pkg::DIV_W-1:0]         d_ff;
   logic                              zero_ff, sat_ff;

   gtp_pkg::uop_type                  uop;
   gtp_pkg::mac_ctl_type              mac_ctl;
   logic [gtp_pkg::LIMB_W-1:0]        op_a, op_b;
   logic [gtp_pkg::PROD_W-1:0]        prod;
   logic [gtp_pkg::ACC_W-1:0]         acc;

   logic [gtp_pkg::COEFF_W-1:0]       b_mag;
   logic [gtp_pkg::STATE_W-1:0]       s0_mag, s1_mag;
   logic [gtp_pkg::BLEN_W-1:0]        n_clamp;

   logic signed [gtp_pkg::SUM_W-1:0]  rec_sum;
   logic [gtp_pkg::STATE_W-1:0]       s0_next;

   logic                              q_neg, q_sat;
   logic                              div_load, div_busy;
   logic [gtp_pkg::QUO_W-1:0]         div_quo;
   logic                              in_xfer, out_free;

   function automatic logic [gtp_pkg::LIMB_W-1:0] opnd_mux(
      input logic [gtp_pkg::OP_W-1:0]    code,
      input logic [gtp_pkg::COEFF_W-1:0] bm,
      input logic [gtp_pkg::STATE_W-1:0] s0m,
      input logic [gtp_pkg::STATE_W-1:0] s1m,
      input logic [gtp_pkg::M_W-1:0]     m,
      input logic [gtp_pkg::BLEN_W-1:0]  n);
      logic [gtp_pkg::LIMB_W-1:0] r;
      case (code)
         gtp_pkg::OP_B:    r = gtp_pkg::LIMB_W'(bm);
         gtp_pkg::OP_S0LO: r = s0m[gtp_pkg::LIMB_W-1:0];
         gtp_pkg::OP_S0HI: r = s0m[2*gtp_pkg::LIMB_W-1:gtp_pkg::LIMB_W];
         gtp_pkg::OP_S1LO: r = s1m[gtp_pkg::LIMB_W-1:0];
         gtp_pkg::OP_S1HI: r = s1m[2*gtp_pkg::LIMB_W-1:gtp_pkg::LIMB_W];
         gtp_pkg::OP_M0:   r = m[gtp_pkg::LIMB_W-1:0];
         gtp_pkg::OP_M1:   r = m[2*gtp_pkg::LIMB_W-1:gtp_pkg::LIMB_W];
         gtp_pkg::OP_M2:   r = m[3*gtp_pkg::LIMB_W-1:2*gtp_pkg::LIMB_W];
         gtp_pkg::OP_M3:   r = m[4*gtp_pkg::LIMB_W-1:3*gtp_pkg::LIMB_W];
         gtp_pkg::OP_N:    r = gtp_pkg::LIMB_W'(n);
         default:          r = '0;
      endcase
      return r;
   endfunction

   assign in_xfer  = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Sign-magnitude operands for the unsigned multiplier.
   always_comb begin
      b_mag  = coeff_b_ff[gtp_pkg::COEFF_W-1] ? (~coeff_b_ff + 1'b1) : coeff_b_ff;
      s0_mag = s0_ff[gtp_pkg::STATE_W-1] ? (~s0_ff + 1'b1) : s0_ff;
      s1_mag = s1_ff[gtp_pkg::STATE_W-1] ? (~s1_ff + 1'b1) : s1_ff;
      if (block_len_ff == '0) begin
         n_clamp = gtp_pkg::BLEN_W'(1);
      end else if (block_len_ff > gtp_pkg::BLEN_W'(gtp_pkg::MAX_BLOCK)) begin
         n_clamp = gtp_pkg::BLEN_W'(gtp_pkg::MAX_BLOCK);
      end else begin
         n_clamp = block_len_ff;
      end
   end

   always_comb begin
      uop  = gtp_pkg::gtp_uop(step_ff);
      op_a = opnd_mux(uop.opa, b_mag, s0_mag, s1_mag, m_ff, n_clamp);
      op_b = opnd_mux(uop.opb, b_mag, s0_mag, s1_mag, m_ff, n_clamp);
      mac_ctl.en    = (state_ff == S_MUL) && uop.acc_en;
      mac_ctl.clr   = uop.clr;
      mac_ctl.shamt = uop.shamt;
      case (uop.negk)
         gtp_pkg::NEGK_REC:
            mac_ctl.neg = coeff_b_ff[gtp_pkg::COEFF_W-1] ^ s1_ff[gtp_pkg::STATE_W-1];
         gtp_pkg::NEGK_CROSS:
            mac_ctl.neg = ~(coeff_b_ff[gtp_pkg::COEFF_W-1] ^ s0_ff[gtp_pkg::STATE_W-1]
                            ^ s1_ff[gtp_pkg::STATE_W-1]);
         default:
            mac_ctl.neg = 1'b0;
      endcase
   end

   gtp_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod),
      .acc   (acc)
   );

   // New state: x - s2 + floor(B*s1 / 2^16), saturated to the state width.
   always_comb begin
      rec_sum = gtp_pkg::SUM_W'($signed(x_ff))
              - gtp_pkg::SUM_W'($signed(s2_ff))
              + $signed(acc[gtp_pkg::FRAC_W+gtp_pkg::SUM_W-1:gtp_pkg::FRAC_W]);
      if (rec_sum[gtp_pkg::SUM_W-1:gtp_pkg::STATE_W-1] == '0 ||
          rec_sum[gtp_pkg::SUM_W-1:gtp_pkg::STATE_W-1] == '1) begin
         s0_next = rec_sum[gtp_pkg::STATE_W-1:0];
      end else if (rec_sum[gtp_pkg::SUM_W-1]) begin
         s0_next = {1'b1, {(gtp_pkg::STATE_W-1){1'b0}}};
      end else begin
         s0_next = {1'b0, {(gtp_pkg::STATE_W-1){1'b1}}};
      end
   end

   // The quotient fits in 32 bits only if the part above the low 32 bits of
   // Q/2^15 is below N^2.
   always_comb begin
      q_neg = acc[gtp_pkg::ACC_W-1];
      q_sat = acc[gtp_pkg::ACC_W-1:gtp_pkg::SAT_LO]
              >= (gtp_pkg::ACC_W - gtp_pkg::SAT_LO)'(d_ff);
      div_load = (state_ff == S_DSET) && !q_neg && !q_sat;
   end

   gtp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .load     (div_load),
      .rem_init (acc[gtp_pkg::SAT_LO+gtp_pkg::REM_W-1:gtp_pkg::SAT_LO]),
      .quo_init (acc[gtp_pkg::SAT_LO-1:gtp_pkg::QSCALE_SH]),
      .divisor  (d_ff),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      case (state_ff)
         S_IDLE: begin
            if (in_xfer) begin
               state_in = S_MUL;
               step_in  = gtp_pkg::STEP_REC_FIRST;
            end
         end
         S_MUL: begin
            step_in = step_ff + 1'b1;
            if (step_ff == gtp_pkg::STEP_REC_END) begin
               state_in = S_FIN;
            end else if (step_ff == gtp_pkg::STEP_NN) begin
               state_in = S_DSET;
            end
         end
         S_FIN: begin
            if (last_ff) begin
               state_in = S_MUL;
               step_in  = gtp_pkg::STEP_PWR_FIRST;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DSET: begin
            state_in = div_load ? S_DIV : S_OUT;
         end
         S_DIV: begin
            if (!div_busy) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         coeff_b_ff   <= gtp_pkg::COEFF_B_RST;
         block_len_ff <= gtp_pkg::BLOCK_LEN_RST;
         s1_ff        <= '0;
         s2_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               gtp_pkg::CSR_COEFF_B:   coeff_b_ff   <= csr_wdata;
               gtp_pkg::CSR_BLOCK_LEN: block_len_ff <= csr_wdata[gtp_pkg::BLEN_W-1:0];
               default: ;
            endcase
         end
         if (state_ff == S_FIN && !last_ff) begin
            s2_ff <= s1_ff;
            s1_ff <= s0_next;
         end
         if (state_ff == S_DSET) begin
            s1_ff <= '0;
            s2_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_xfer) begin
         x_ff    <= req_chan.sample;
         last_ff <= req_chan.last;
      end
      if (state_ff == S_FIN) begin
         s0_ff <= s0_next;
      end
      if (state_ff == S_MUL && uop.save_m) begin
         m_ff <= acc[gtp_pkg::M_W-1:0];
      end
      if (state_ff == S_MUL && step_ff == gtp_pkg::STEP_NN) begin
         d_ff <= prod[gtp_pkg::DIV_W-1:0];
      end
      if (state_ff == S_DSET) begin
         zero_ff <= q_neg;
         sat_ff  <= q_sat;
      end
      if (state_ff == S_OUT && out_free) begin
         if (zero_ff) begin
            power_ff <= '0;
         end else if (sat_ff) begin
            power_ff <= '1;
         end else begin
            power_ff <= div_quo;
         end
      end
   end

   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.power = power_ff;

endmodule

// ===== hw/rtl/gtp_mac.sv =====
module gtp_mac (
   input  logic                         clock,
   input  gtp_pkg::mac_ctl_type         ctl,
   input  logic [gtp_pkg::LIMB_W-1:0]   op_a,
   input  logic [gtp_pkg::LIMB_W-1:0]   op_b,
   output logic [gtp_pkg::PROD_W-1:0]   prod,
   output logic [gtp_pkg::ACC_W-1:0]    acc
);

   logic [gtp_pkg::ACC_W-1:0] acc_ff;
   logic [gtp_pkg::ACC_W-1:0] acc_in;
   logic [gtp_pkg::ACC_W-1:0] shifted;
   logic [gtp_pkg::ACC_W-1:0] addend;
   logic [gtp_pkg::ACC_W-1:0] base;

   assign prod = gtp_pkg::PROD_W'(op_a) * gtp_pkg::PROD_W'(op_b);

   always_comb begin
      shifted = gtp_pkg::ACC_W'(prod) << ctl.shamt;
      addend  = ctl.neg ? (~shifted + 1'b1) : shifted;
      base    = ctl.clr ? '0 : acc_ff;
      acc_in  = base + addend;
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

// ===== hw/rtl/gtp_div.sv =====
module gtp_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  logic [gtp_pkg::REM_W-1:0]   rem_init,
   input  logic [gtp_pkg::QUO_W-1:0]   quo_init,
   input  logic [gtp_pkg::DIV_W-1:0]   divisor,
   output logic                        busy,
   output logic [gtp_pkg::QUO_W-1:0]   quotient
);

   logic                        busy_ff;
   logic [gtp_pkg::CNT_W-1:0]   cnt_ff;
   logic [gtp_pkg::REM_W-1:0]   rem_ff;
   logic [gtp_pkg::REM_W-1:0]   rem_in;
   logic [gtp_pkg::QUO_W-1:0]   quo_ff;
   logic [gtp_pkg::DIV_W-1:0]   trial;
   logic                        fits;

   // The quotient register starts as the low dividend bits; each step
   // shifts one dividend bit into the remainder and one quotient bit in.
   always_comb begin
      trial  = {rem_ff, quo_ff[gtp_pkg::QUO_W-1]};
      fits   = (trial >= divisor);
      rem_in = fits ? gtp_pkg::REM_W'(trial - divisor) : trial[gtp_pkg::REM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (load) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == gtp_pkg::CNT_W'(gtp_pkg::QUO_W - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff <= rem_init;
         quo_ff <= quo_init;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[gtp_pkg::QUO_W-2:0], fits};
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// ===== hw/rtl/gtp_checker.sv =====
module gtp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_last,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [gtp_pkg::POWER_W-1:0]   rsp_power
);

   // A sample that does not close a block keeps the block busy after its transfer
   // through both partial products and the saturating update, and then frees it.
   a_rec_timing: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_last)
      |=> !req_ready ##1 !req_ready ##1 !req_ready ##1 req_ready)
      else $error("non-last sample did not finish in four cycles");

   // A sample that does not close a block produces no result while it is processed.
   a_rec_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_last)
      |=> !$rose(rsp_valid) ##1 !$rose(rsp_valid) ##1 !$rose(rsp_valid)
          ##1 !$rose(rsp_valid))
      else $error("result appeared after a non-last sample");

   // A new result is loaded only as the sequencer returns to idle.
   a_rsp_at_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result loaded while the block was still busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_power)))
      else $error("stalled result changed");

endmodule

bind goertzel_tone_power gtp_checker u_gtp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_last  (req_chan.last),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_power (rsp_chan.power)
);
